### hw/rtl/cau_pkg.sv
// shared types, constants and helpers for the complex arithmetic unit
// no dependencies
package cau_pkg;

  localparam int unsigned FracBitsDef = 8;
  localparam int unsigned QuotBits    = 16;
  localparam int unsigned QueueDepth  = 4;
  localparam int unsigned QueueIdxW   = $clog2(QueueDepth);
  localparam int unsigned QueueCntW   = $clog2(QueueDepth + 1);

  // operation codes on the input channel
  typedef enum logic [2:0] {
    OP_ADD   = 3'd0,
    OP_MUL   = 3'd1,
    OP_DIV   = 3'd2,
    OP_CONJ  = 3'd3,
    OP_SCALE = 3'd4
  } op_t;

  // classified work kind carried to the back end
  typedef enum logic [2:0] {
    KIND_ADD,
    KIND_MUL,
    KIND_DIV,
    KIND_CONJ,
    KIND_SCALE,
    KIND_NONE
  } kind_t;

  typedef struct packed {
    kind_t              kind;
    logic signed [15:0] a_re;
    logic signed [15:0] a_im;
    logic signed [15:0] b_re;
    logic signed [15:0] b_im;
    logic signed [15:0] scalar_value;
  } cau_item_t;

  typedef struct packed {
    logic               ovf;
    logic signed [15:0] val;
  } sat_t;

  // clamp a wide signed value to 16 bits
  function automatic sat_t sat16(input logic signed [47:0] x);
    sat_t r;
    if (x > 48'sd32767) begin
      r.ovf = 1'b1;
      r.val = 16'sh7fff;
    end else if (x < -48'sd32768) begin
      r.ovf = 1'b1;
      r.val = 16'sh8000;
    end else begin
      r.ovf = 1'b0;
      r.val = x[15:0];
    end
    return r;
  endfunction

endpackage

### hw/rtl/cau_if.sv
// channel interfaces for the complex arithmetic unit
// no dependencies
interface cau_in_if;
  logic               valid;
  logic               ready;
  logic [2:0]         operation;
  logic signed [15:0] a_re;
  logic signed [15:0] a_im;
  logic signed [15:0] b_re;
  logic signed [15:0] b_im;
  logic signed [15:0] scalar_value;

  modport source(output valid, operation, a_re, a_im, b_re, b_im, scalar_value,
                 input ready);
  modport sink(input valid, operation, a_re, a_im, b_re, b_im, scalar_value,
               output ready);
endinterface

interface cau_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] res_re;
  logic signed [15:0] res_im;
  logic               overflow;
  logic               divide_by_zero;

  modport source(output valid, res_re, res_im, overflow, divide_by_zero,
                 input ready);
  modport sink(input valid, res_re, res_im, overflow, divide_by_zero,
               output ready);
endinterface

### hw/rtl/cau_front.sv
// front end: accepts requests, classifies the operation, queues work items
// depends on cau_pkg and cau_in_if
module cau_front (
  input  logic                clk,
  input  logic                rst,
  cau_in_if.sink              operand,
  output cau_pkg::cau_item_t  item,
  output logic                item_valid,
  input  logic                item_pop
);

  cau_pkg::cau_item_t              mem [cau_pkg::QueueDepth];
  logic [cau_pkg::QueueIdxW-1:0]   wr_ptr;
  logic [cau_pkg::QueueIdxW-1:0]   rd_ptr;
  logic [cau_pkg::QueueCntW-1:0]   count;
  logic                            push;
  logic                            pop;
  cau_pkg::cau_item_t              cls;

  // classify the operation code
  always_comb begin
    cls.a_re         = operand.a_re;
    cls.a_im         = operand.a_im;
    cls.b_re         = operand.b_re;
    cls.b_im         = operand.b_im;
    cls.scalar_value = operand.scalar_value;
    unique case (operand.operation)
      cau_pkg::OP_ADD:   cls.kind = cau_pkg::KIND_ADD;
      cau_pkg::OP_MUL:   cls.kind = cau_pkg::KIND_MUL;
      cau_pkg::OP_DIV:   cls.kind = cau_pkg::KIND_DIV;
      cau_pkg::OP_CONJ:  cls.kind = cau_pkg::KIND_CONJ;
      cau_pkg::OP_SCALE: cls.kind = cau_pkg::KIND_SCALE;
      default:           cls.kind = cau_pkg::KIND_NONE;
    endcase
  end

  // queue handshake
  assign operand.ready = (count != cau_pkg::QueueCntW'(cau_pkg::QueueDepth));
  assign push          = operand.valid && operand.ready;
  assign item_valid    = (count != '0);
  assign pop           = item_pop && item_valid;
  assign item          = mem[rd_ptr];

  // queue pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= wr_ptr + 1'b1;
      if (pop)  rd_ptr <= rd_ptr + 1'b1;
      count <= count + (push ? 1'b1 : 1'b0) - (pop ? 1'b1 : 1'b0);
    end
  end

  // queue storage
  always_ff @(posedge clk) begin
    if (push) mem[wr_ptr] <= cls;
  end

endmodule

### hw/rtl/cau_back.sv
// back end: product stage, combine stage, pipelined divider, output register
// depends on cau_pkg and cau_out_if
module cau_back #(
  parameter int unsigned FRAC_BITS = cau_pkg::FracBitsDef
) (
  input  logic                clk,
  input  logic                rst,
  input  cau_pkg::cau_item_t  item,
  input  logic                item_valid,
  output logic                item_pop,
  cau_out_if.source           result
);

  localparam int unsigned QB = cau_pkg::QuotBits;
  localparam int unsigned RW = 49 + FRAC_BITS;

  typedef struct packed {
    logic               valid;
    cau_pkg::kind_t     kind;
    logic               dbz;
    logic signed [15:0] res_re;
    logic signed [15:0] res_im;
    logic               ovf;
    logic [RW-1:0]      rem_re;
    logic [RW-1:0]      rem_im;
    logic [QB-1:0]      q_re;
    logic [QB-1:0]      q_im;
    logic               neg_re;
    logic               neg_im;
    logic               dovf_re;
    logic               dovf_im;
    logic [31:0]        norm;
  } div_t;

  typedef struct packed {
    logic               ovf;
    logic signed [15:0] val;
  } part_t;

  logic en;
  assign en       = !result.valid || result.ready;
  assign item_pop = en && item_valid;

  // stage 1: all products
  logic                v1;
  cau_pkg::cau_item_t  it1;
  logic signed [31:0]  p_rr, p_ii, p_ri, p_ir, p_sr, p_si, p_bb_r, p_bb_i;

  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else if (en) v1 <= item_valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      it1    <= item;
      p_rr   <= item.a_re * item.b_re;
      p_ii   <= item.a_im * item.b_im;
      p_ri   <= item.a_re * item.b_im;
      p_ir   <= item.a_im * item.b_re;
      p_sr   <= item.scalar_value * item.a_re;
      p_si   <= item.scalar_value * item.a_im;
      p_bb_r <= item.b_re * item.b_re;
      p_bb_i <= item.b_im * item.b_im;
    end
  end

  // stage 2: sums, shifts, saturation and divide magnitudes
  logic signed [32:0] mul_re, mul_im, num_re, num_im;
  logic signed [47:0] wide_re, wide_im;
  cau_pkg::sat_t      sat_re, sat_im;
  logic [31:0]        nmag_re, nmag_im, norm_c;

  always_comb begin
    mul_re  = 33'(p_rr) - 33'(p_ii);
    mul_im  = 33'(p_ri) + 33'(p_ir);
    num_re  = 33'(p_rr) + 33'(p_ii);
    num_im  = 33'(p_ir) - 33'(p_ri);
    nmag_re = num_re[32] ? 32'(-num_re) : 32'(num_re);
    nmag_im = num_im[32] ? 32'(-num_im) : 32'(num_im);
    norm_c  = 32'($unsigned(p_bb_r)) + 32'($unsigned(p_bb_i));
    unique case (it1.kind)
      cau_pkg::KIND_ADD: begin
        wide_re = 48'(it1.a_re) + 48'(it1.b_re);
        wide_im = 48'(it1.a_im) + 48'(it1.b_im);
      end
      cau_pkg::KIND_MUL: begin
        wide_re = 48'(mul_re >>> FRAC_BITS);
        wide_im = 48'(mul_im >>> FRAC_BITS);
      end
      cau_pkg::KIND_CONJ: begin
        wide_re = 48'(it1.a_re);
        wide_im = -48'(it1.a_im);
      end
      cau_pkg::KIND_SCALE: begin
        wide_re = 48'(p_sr >>> FRAC_BITS);
        wide_im = 48'(p_si >>> FRAC_BITS);
      end
      default: begin
        wide_re = '0;
        wide_im = '0;
      end
    endcase
    sat_re = cau_pkg::sat16(wide_re);
    sat_im = cau_pkg::sat16(wide_im);
  end

  logic               v2;
  cau_pkg::kind_t     kind2;
  logic signed [15:0] res_re2, res_im2;
  logic               ovf2, neg_re2, neg_im2;
  logic [31:0]        nmag_re2, nmag_im2, norm2;

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else if (en) v2 <= v1;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      kind2    <= it1.kind;
      res_re2  <= sat_re.val;
      res_im2  <= sat_im.val;
      ovf2     <= sat_re.ovf || sat_im.ovf;
      neg_re2  <= num_re[32];
      neg_im2  <= num_im[32];
      nmag_re2 <= nmag_re;
      nmag_im2 <= nmag_im;
      norm2    <= norm_c;
    end
  end

  // stage 3: quotient range check, seeds the divider
  div_t          st [QB+1];
  div_t          seed;
  logic [RW-1:0] n_re, n_im, d_top;

  always_comb begin
    n_re         = RW'(nmag_re2) << FRAC_BITS;
    n_im         = RW'(nmag_im2) << FRAC_BITS;
    d_top        = RW'(norm2) << QB;
    seed.valid   = v2;
    seed.kind    = kind2;
    seed.dbz     = (norm2 == '0);
    seed.res_re  = res_re2;
    seed.res_im  = res_im2;
    seed.ovf     = ovf2;
    seed.rem_re  = n_re;
    seed.rem_im  = n_im;
    seed.q_re    = '0;
    seed.q_im    = '0;
    seed.neg_re  = neg_re2;
    seed.neg_im  = neg_im2;
    seed.dovf_re = (n_re >= d_top);
    seed.dovf_im = (n_im >= d_top);
    seed.norm    = norm2;
  end

  always_ff @(posedge clk) begin
    if (rst) st[0].valid <= 1'b0;
    else if (en) st[0].valid <= seed.valid;
    if (en) st[0][$bits(div_t)-2:0] <= seed[$bits(div_t)-2:0];
  end

  // restoring divider, one quotient bit per stage
  for (genvar j = 0; j < QB; j++) begin : g_div
    localparam int unsigned BIT = QB - 1 - j;
    div_t          nx;
    logic [RW-1:0] dsh;

    always_comb begin
      nx  = st[j];
      dsh = RW'(st[j].norm) << BIT;
      if (st[j].rem_re >= dsh) begin
        nx.rem_re    = st[j].rem_re - dsh;
        nx.q_re[BIT] = 1'b1;
      end
      if (st[j].rem_im >= dsh) begin
        nx.rem_im    = st[j].rem_im - dsh;
        nx.q_im[BIT] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) st[j+1].valid <= 1'b0;
      else if (en) st[j+1].valid <= nx.valid;
      if (en) st[j+1][$bits(div_t)-2:0] <= nx[$bits(div_t)-2:0];
    end
  end

  // sign and clamp one quotient part
  function automatic part_t div_part(input logic [QB-1:0] q, input logic neg,
                                     input logic dovf);
    part_t              r;
    logic signed [QB:0] sq;
    sq = neg ? -$signed({1'b0, q}) : $signed({1'b0, q});
    if (dovf || (!neg && q > QB'(32767))) begin
      r.ovf = 1'b1;
      r.val = 16'sh7fff;
    end else if (neg && ({1'b0, q} > (QB+1)'(32768))) begin
      r.ovf = 1'b1;
      r.val = 16'sh8000;
    end else begin
      r.ovf = 1'b0;
      r.val = sq[15:0];
    end
    if (dovf && neg) r.val = 16'sh8000;
    return r;
  endfunction

  // final result selection
  div_t  last;
  part_t dq_re, dq_im;
  logic signed [15:0] fin_re, fin_im;
  logic               fin_ovf, fin_dbz;

  assign last = st[QB];

  always_comb begin
    dq_re = div_part(last.q_re, last.neg_re, last.dovf_re);
    dq_im = div_part(last.q_im, last.neg_im, last.dovf_im);
    if (last.kind == cau_pkg::KIND_DIV) begin
      if (last.dbz) begin
        fin_re  = '0;
        fin_im  = '0;
        fin_ovf = 1'b0;
        fin_dbz = 1'b1;
      end else begin
        fin_re  = dq_re.val;
        fin_im  = dq_im.val;
        fin_ovf = dq_re.ovf || dq_im.ovf;
        fin_dbz = 1'b0;
      end
    end else begin
      fin_re  = last.res_re;
      fin_im  = last.res_im;
      fin_ovf = last.ovf;
      fin_dbz = 1'b0;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) result.valid <= 1'b0;
    else if (en) result.valid <= last.valid;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      result.res_re         <= fin_re;
      result.res_im         <= fin_im;
      result.overflow       <= fin_ovf;
      result.divide_by_zero <= fin_dbz;
    end
  end

`ifndef SYNTH
  // divide by zero gives a clean zero result
  a_dbz_zero: assert property (@(posedge clk) disable iff (rst)
    result.valid && result.divide_by_zero |->
      result.res_re == 16'sd0 && result.res_im == 16'sd0 && !result.overflow)
    else $error("divide by zero result not zero");

  // flags are exclusive
  a_flags: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.overflow && result.divide_by_zero))
    else $error("overflow and divide by zero both set");

  // a stalled output freezes the divider tail
  a_stall: assert property (@(posedge clk) disable iff (rst)
    !en |=> $stable(last.valid) && $stable(last.q_re) && $stable(last.q_im))
    else $error("pipeline moved during stall");
`endif

endmodule

### hw/rtl/complex_arithmetic_unit.sv
// top level of the complex arithmetic unit: front end, queue, back end
// depends on cau_pkg, cau_if, cau_front, cau_back
//
// channel   dir  contents
// operand   in   operation, a_re, a_im, b_re, b_im, scalar_value
// result    out  res_re, res_im, overflow, divide_by_zero
//
// one request per cycle sustained while results are taken; after acceptance a request is
// queued, then passes the product stage, combine stage, range check, 16 divider stages
// (one quotient bit each) and the output register
// every operation takes the same path, so results leave in order
// synchronous reset clears the queue and all pipeline valid bits
// a stalled result freezes the back end; the queue takes requests until full
module complex_arithmetic_unit #(
  parameter int unsigned FRAC_BITS = cau_pkg::FracBitsDef
) (
  input logic       clk,
  input logic       rst,
  cau_in_if.sink    operand,
  cau_out_if.source result
);

  cau_pkg::cau_item_t item;
  logic               item_valid;
  logic               item_pop;

  // request intake and queue
  cau_front u_front (
    .clk        (clk),
    .rst        (rst),
    .operand    (operand),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop)
  );

  // arithmetic pipeline
  cau_back #(
    .FRAC_BITS (FRAC_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item       (item),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .result     (result)
  );

endmodule
